// ----- rtl/core/ucv_pkg.sv -----
// Shared types and constants for the UTF-8 control character validator.
`default_nettype none

package ucv_pkg;

	// Width of the character counter and the widened form used for saturation
	localparam int COUNT_WIDTH = 16;
	localparam int CNT_EXT_W   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Control code point limits
	localparam logic [20:0] CTRL_C0_MAX = 21'h00001f;
	localparam logic [20:0] CTRL_DEL    = 21'h00007f;
	localparam logic [20:0] CTRL_C1_MIN = 21'h000080;
	localparam logic [20:0] CTRL_C1_MAX = 21'h00009f;

	// Verdict codes
	typedef enum logic [1:0] {
		VERDICT_VALID    = 2'd0,
		VERDICT_CONTROL  = 2'd1,
		VERDICT_MISS_CNT = 2'd2,
		VERDICT_BAD_LEAD = 2'd3
	} verdict_t;

	// Byte classes decided by the front end
	typedef enum logic [2:0] {
		KIND_ASCII = 3'd0,
		KIND_LEAD2 = 3'd1,
		KIND_LEAD3 = 3'd2,
		KIND_LEAD4 = 3'd3,
		KIND_CONT  = 3'd4,
		KIND_BAD   = 3'd5
	} kind_t;

	// One classified byte as it sits in the queue
	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
	} ucv_item_t;

	// Push side of the queue
	typedef struct packed {
		logic      push;
		ucv_item_t item;
	} ucv_push_t;

	// Pop side of the queue
	typedef struct packed {
		logic      valid;
		ucv_item_t item;
	} ucv_head_t;

endpackage

`default_nettype wire

// ----- rtl/core/ucv_front.sv -----
// Front end: takes request bytes and classifies them by UTF-8 bit pattern.
`default_nettype none

module ucv_front
	import ucv_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_value,
	input  wire logic       queue_full,
	output ucv_push_t       push_o
);

	kind_t kind;

	// Lead byte pattern decode
	always_comb begin
		unique casez (byte_value)
			8'b0???????: kind = KIND_ASCII;
			8'b10??????: kind = KIND_CONT;
			8'b110?????: kind = KIND_LEAD2;
			8'b1110????: kind = KIND_LEAD3;
			8'b11110???: kind = KIND_LEAD4;
			default:     kind = KIND_BAD;
		endcase
	end

	assign in_ready               = !queue_full;
	assign push_o.push            = in_valid && !queue_full;
	assign push_o.item.kind       = kind;
	assign push_o.item.byte_value = byte_value;

endmodule

`default_nettype wire

// ----- rtl/core/ucv_queue.sv -----
// Short queue of classified bytes between front end and decoder.
`default_nettype none

module ucv_queue
	import ucv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ucv_push_t  push_i,
	input  wire logic       pop,
	output logic            full,
	output ucv_head_t       head_o
);

	ucv_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full         = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_o.valid = (count_q != '0);
	assign head_o.item  = mem_q[rd_ptr_q];
	assign do_pop       = pop && head_o.valid;

	// Storage
	always_ff @(posedge clk) begin
		if (push_i.push) begin
			mem_q[wr_ptr_q] <= push_i.item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_i.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_i.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push_i.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ucv_back.sv -----
// Back end: UTF-8 decoder state, control check and verdict output register.
`default_nettype none

module ucv_back
	import ucv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ucv_head_t   head_i,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	output logic [15:0]      char_number,
	output logic [20:0]      detail_value,
	output logic [2:0]       sequence_length
);

	// Decoder state
	logic                   skip_q;
	logic [1:0]             rem_q;
	logic [2:0]             seq_q;
	logic [20:0]            acc_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   out_valid_q;

	logic                   skip_d;
	logic [1:0]             rem_d;
	logic [2:0]             seq_d;
	logic [20:0]            acc_d;
	logic [COUNT_WIDTH-1:0] cnt_d;

	logic                   emit;
	verdict_t               emit_verdict;
	logic [20:0]            emit_detail;
	logic [2:0]             emit_len;
	logic [20:0]            code;
	logic                   code_from_zero;
	logic                   judge;
	logic                   is_ctrl;
	logic [CNT_EXT_W-1:0]   cnt_ext;
	logic [15:0]            cnt_sat;
	logic [7:0]             b;

	assign b = head_i.item.byte_value;

	// Take the next request when the output register is free or draining
	assign pop = head_i.valid && (!out_valid_q || out_ready);

	// Saturated character number
	assign cnt_ext = CNT_EXT_W'(cnt_q);
	assign cnt_sat = (cnt_ext > CNT_EXT_W'(16'hffff)) ? 16'hffff : cnt_ext[15:0];

	// Control code point check
	assign is_ctrl = (code <= CTRL_C0_MAX) || (code == CTRL_DEL) ||
	                 ((code >= CTRL_C1_MIN) && (code <= CTRL_C1_MAX));

	// Decode step
	always_comb begin
		skip_d         = skip_q;
		rem_d          = rem_q;
		seq_d          = seq_q;
		acc_d          = acc_q;
		cnt_d          = cnt_q;
		emit           = 1'b0;
		emit_verdict   = VERDICT_VALID;
		emit_detail    = '0;
		emit_len       = '0;
		code           = 21'(b);
		code_from_zero = 1'b0;
		judge          = 1'b0;

		if (skip_q) begin
			if (b == 8'h00) begin
				skip_d = 1'b0;
				rem_d  = '0;
				seq_d  = '0;
				acc_d  = '0;
				cnt_d  = COUNT_WIDTH'(1);
			end
		end else if (rem_q == 2'd0) begin
			unique case (head_i.item.kind)
				KIND_ASCII: begin
					code           = 21'(b);
					code_from_zero = (b == 8'h00);
					judge          = 1'b1;
				end
				KIND_LEAD2: begin
					rem_d = 2'd1;
					seq_d = 3'd2;
					acc_d = 21'(b[4:0]);
				end
				KIND_LEAD3: begin
					rem_d = 2'd2;
					seq_d = 3'd3;
					acc_d = 21'(b[3:0]);
				end
				KIND_LEAD4: begin
					rem_d = 2'd3;
					seq_d = 3'd4;
					acc_d = 21'(b[2:0]);
				end
				KIND_CONT, KIND_BAD: begin
					emit         = 1'b1;
					emit_verdict = VERDICT_BAD_LEAD;
					emit_detail  = 21'(b);
					skip_d       = 1'b1;
					rem_d        = '0;
					seq_d        = '0;
					acc_d        = '0;
					cnt_d        = COUNT_WIDTH'(1);
				end
				default: ;
			endcase
		end else if (head_i.item.kind != KIND_CONT) begin
			// Continuation due but not present
			emit         = 1'b1;
			emit_verdict = VERDICT_MISS_CNT;
			emit_detail  = 21'(seq_q - 3'(rem_q));
			emit_len     = seq_q;
			skip_d       = (b != 8'h00);
			rem_d        = '0;
			seq_d        = '0;
			acc_d        = '0;
			cnt_d        = COUNT_WIDTH'(1);
		end else begin
			// Collect continuation payload
			acc_d = {acc_q[14:0], b[5:0]};
			rem_d = rem_q - 2'd1;
			if (rem_q == 2'd1) begin
				seq_d = '0;
				code  = {acc_q[14:0], b[5:0]};
				judge = 1'b1;
			end
		end

		// Judge a completed code point
		if (judge) begin
			if (code == 21'd0) begin
				emit         = 1'b1;
				emit_verdict = VERDICT_VALID;
				skip_d       = !code_from_zero;
				rem_d        = '0;
				seq_d        = '0;
				acc_d        = '0;
				cnt_d        = COUNT_WIDTH'(1);
			end else if (is_ctrl) begin
				emit         = 1'b1;
				emit_verdict = VERDICT_CONTROL;
				emit_detail  = code;
				skip_d       = 1'b1;
				rem_d        = '0;
				seq_d        = '0;
				acc_d        = '0;
				cnt_d        = COUNT_WIDTH'(1);
			end else if (cnt_q != '1) begin
				cnt_d = cnt_q + 1'b1;
			end
		end
	end

	// Decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
			rem_q  <= '0;
			seq_q  <= '0;
			acc_q  <= '0;
			cnt_q  <= COUNT_WIDTH'(1);
		end else if (pop) begin
			skip_q <= skip_d;
			rem_q  <= rem_d;
			seq_q  <= seq_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			verdict         <= emit_verdict;
			char_number     <= cnt_sat;
			detail_value    <= emit_detail;
			sequence_length <= emit_len;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/utf8_control_char_validator_core.sv -----
// Bytes pass the four-entry queue, which decouples input from output stalls; a verdict
// passes the output register. Throughput: one byte per cycle while the queue is not full.
// A byte causes at most one verdict; bytes that cause none leave no output.
// Reset (arst_n low, asynchronous) empties the queue and output register and puts the
// decoder at the start of a new string with the character number at one.
`default_nettype none

module utf8_control_char_validator_core
	import ucv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	output logic [15:0]      char_number,
	output logic [20:0]      detail_value,
	output logic [2:0]       sequence_length
);

	ucv_push_t push;
	ucv_head_t head;
	logic      queue_full;
	logic      pop;

	// Classifier
	ucv_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.queue_full (queue_full),
		.push_o     (push)
	);

	// Decoupling queue
	ucv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_i (push),
		.pop    (pop),
		.full   (queue_full),
		.head_o (head)
	);

	// Decoder and verdict output
	ucv_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_i          (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.char_number     (char_number),
		.detail_value    (detail_value),
		.sequence_length (sequence_length)
	);

endmodule

`default_nettype wire

// ----- rtl/core/ucv_checker.sv -----
// Port-level checks for the validator and their binding to the top level.
`default_nettype none

module ucv_checker
	import ucv_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  verdict,
	input wire logic [15:0] char_number,
	input wire logic [20:0] detail_value,
	input wire logic [2:0]  sequence_length
);

	// A stalled verdict holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) &&
		$stable(char_number) && $stable(detail_value) && $stable(sequence_length))
		else $error("verdict changed while stalled");

	// Valid verdict carries no detail
	a_valid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_VALID |-> detail_value == '0 && sequence_length == '0)
		else $error("valid verdict with detail");

	// Missing continuation: length 2..4 and ordinal below it
	a_miss_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_MISS_CNT |->
		sequence_length >= 3'd2 && sequence_length <= 3'd4 &&
		detail_value >= 21'd1 && detail_value < 21'(sequence_length))
		else $error("bad missing continuation detail");

	// Length only reported with missing continuation
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict != VERDICT_MISS_CNT |-> sequence_length == '0)
		else $error("sequence length on wrong verdict");

	// Character numbers start at one
	a_num_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_number != '0)
		else $error("character number zero");

endmodule

bind utf8_control_char_validator_core ucv_checker u_ucv_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.verdict         (verdict),
	.char_number     (char_number),
	.detail_value    (detail_value),
	.sequence_length (sequence_length)
);

`default_nettype wire

// ----- dv/ucv_verdict_checker.sv -----
// Verdict checker: predicts the verdict of each string and compares it with the block's output.
`default_nettype none

module ucv_verdict_checker
	import ucv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  byte_value,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  verdict,
	input  wire logic [15:0] char_number,
	input  wire logic [20:0] detail_value,
	input  wire logic [2:0]  sequence_length,
	output int               fail_count,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// One predicted verdict
	typedef struct packed {
		verdict_t    verdict;
		logic [15:0] char_number;
		logic [20:0] detail;
		logic [2:0]  seq_len;
	} verdict_rec_t;

	// Decoder state of the prediction
	logic                   skipping;
	logic [1:0]             conts_due;
	logic [2:0]             seq_bytes;
	logic [20:0]            code_acc;
	logic [COUNT_WIDTH-1:0] char_no;

	verdict_rec_t expected_verdicts[$];
	int           mismatches = 0;

	task automatic restart_string();
		skipping  = 1'b0;
		conts_due = '0;
		seq_bytes = '0;
		code_acc  = '0;
		char_no   = COUNT_WIDTH'(1);
	endtask

	// Queue a verdict at the current character number, saturated to 16 bits
	task automatic post_verdict(input verdict_t v, input logic [20:0] detail,
			input logic [2:0] len);
		verdict_rec_t    rec;
		longint unsigned num;
		num = char_no;
		if (num > 64'hffff) begin
			num = 64'hffff;
		end
		rec.verdict     = v;
		rec.char_number = 16'(num);
		rec.detail      = detail;
		rec.seq_len     = len;
		expected_verdicts.push_back(rec);
	endtask

	// Judge a fully decoded code point
	task automatic judge_code(input logic [20:0] code, input logic from_zero);
		if (code == '0) begin
			post_verdict(VERDICT_VALID, '0, '0);
			restart_string();
			skipping = !from_zero;
		end else if (code <= CTRL_C0_MAX || code == CTRL_DEL ||
				(code >= CTRL_C1_MIN && code <= CTRL_C1_MAX)) begin
			post_verdict(VERDICT_CONTROL, code, '0);
			restart_string();
			skipping = 1'b1;
		end else if (char_no != '1) begin
			char_no++;
		end
	endtask

	// Advance the prediction by one accepted byte
	task automatic decode_byte(input logic [7:0] b);
		if (skipping) begin
			if (b == 8'h00) begin
				restart_string();
			end
		end else if (conts_due == 2'd0) begin
			if (!b[7]) begin
				judge_code(21'(b), b == 8'h00);
			end else if (b[7:5] == 3'b110) begin
				conts_due = 2'd1;
				seq_bytes = 3'd2;
				code_acc  = 21'(b[4:0]);
			end else if (b[7:4] == 4'b1110) begin
				conts_due = 2'd2;
				seq_bytes = 3'd3;
				code_acc  = 21'(b[3:0]);
			end else if (b[7:3] == 5'b11110) begin
				conts_due = 2'd3;
				seq_bytes = 3'd4;
				code_acc  = 21'(b[2:0]);
			end else begin
				post_verdict(VERDICT_BAD_LEAD, 21'(b), '0);
				restart_string();
				skipping = 1'b1;
			end
		end else if (b[7:6] != 2'b10) begin
			// continuation missing; a zero byte ends the string, so no skipping
			post_verdict(VERDICT_MISS_CNT, 21'(seq_bytes - 3'(conts_due)), seq_bytes);
			restart_string();
			skipping = (b != 8'h00);
		end else begin
			code_acc = {code_acc[14:0], b[5:0]};
			conts_due--;
			if (conts_due == 2'd0) begin
				seq_bytes = '0;
				judge_code(code_acc, 1'b0);
			end
		end
	endtask

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t ns: %s", $time, msg);
		end
	endfunction

	// Compare results first, then predict from the accepted request
	always @(posedge clk or negedge arst_n) begin
		verdict_rec_t exp_rec;
		if (!arst_n) begin
			restart_string();
			expected_verdicts.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					note_failure($sformatf("unexpected verdict v=%0d num=%0d detail=%0h len=%0d",
						verdict, char_number, detail_value, sequence_length));
				end else begin
					exp_rec = expected_verdicts.pop_front();
					if (verdict !== exp_rec.verdict || char_number !== exp_rec.char_number ||
							detail_value !== exp_rec.detail ||
							sequence_length !== exp_rec.seq_len) begin
						note_failure($sformatf(
							"verdict mismatch: exp v=%0d num=%0d detail=%0h len=%0d, got v=%0d num=%0d detail=%0h len=%0d",
							exp_rec.verdict, exp_rec.char_number, exp_rec.detail,
							exp_rec.seq_len, verdict, char_number, detail_value,
							sequence_length));
					end
				end
			end
			if (in_valid && in_ready) begin
				decode_byte(byte_value);
			end
		end
		outstanding <= expected_verdicts.size();
		fail_count  <= mismatches;
	end

endmodule

`default_nettype wire

// ----- dv/utf8_control_char_validator_core_tb.sv -----
// Testbench top: drives byte strings into the validator core and reports the verdict.
`default_nettype none

module utf8_control_char_validator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_BYTES = 1500;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_PAD    = 6;
	localparam int unsigned CYCLE_LIMIT  = 600000;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic [7:0]  byte_value      = 8'h00;
	logic        out_ready       = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [1:0]  verdict;
	logic [15:0] char_number;
	logic [20:0] detail_value;
	logic [2:0]  sequence_length;
	int          fail_count;
	int          outstanding;

	int          idle_pct     = 0;
	int          stall_pct    = 0;
	logic        hold_request = 1'b0;
	int          hold_left    = 0;
	int          random_sent  = 0;
	int unsigned cycle_count  = 0;
	logic [7:0]  string_bytes[$];

	utf8_control_char_validator_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.byte_value      (byte_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.char_number     (char_number),
		.detail_value    (detail_value),
		.sequence_length (sequence_length)
	);

	ucv_verdict_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.byte_value      (byte_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.char_number     (char_number),
		.detail_value    (detail_value),
		.sequence_length (sequence_length),
		.fail_count      (fail_count),
		.outstanding     (outstanding)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("utf8_control_char_validator_core test failed");
		$finish;
	end

	// Offer one byte; valid stays up after acceptance until the next falling edge
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		byte_value <= b;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Stop offering, wait for every verdict and let the pipeline empty
	task automatic settle_outputs();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	// Lead byte of a 2..4 byte sequence followed by some continuations
	task automatic push_sequence(input int len, input int n_cont);
		logic [7:0] lead;
		case (len)
			2: lead = $urandom_range(1) ? 8'hc2 : {3'b110, 5'($urandom)};
			3: lead = {4'b1110, 4'($urandom)};
			default: lead = {5'b11110, 3'($urandom)};
		endcase
		string_bytes.push_back(lead);
		for (int i = 0; i < n_cont; i++) begin
			string_bytes.push_back({2'b10, 6'($urandom)});
		end
	endtask

	// Mostly well-formed strings with random content, some broken ones
	task automatic send_random_string();
		int n_chars;
		int pick;
		int len;
		string_bytes.delete();
		n_chars = $urandom_range(8);
		for (int i = 0; i < n_chars; i++) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				string_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
			end else if (pick < 42) begin
				string_bytes.push_back(8'($urandom_range(8'h7f, 8'h01)));
			end else if (pick < 84) begin
				len = $urandom_range(4, 2);
				push_sequence(len, len - 1);
			end else if (pick < 90) begin
				// invalid lead: stray continuation or 11111xxx
				string_bytes.push_back($urandom_range(1) ? {2'b10, 6'($urandom)}
					: {5'b11111, 3'($urandom)});
			end else if (pick < 97) begin
				// truncated sequence broken by a non-continuation byte
				len = $urandom_range(4, 2);
				push_sequence(len, $urandom_range(len - 2));
				string_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h7f))
					: 8'($urandom_range(8'hff, 8'hc0)));
			end else begin
				string_bytes.push_back(8'($urandom));
			end
		end
		string_bytes.push_back(8'h00);
		random_sent += string_bytes.size();
		foreach (string_bytes[i]) begin
			send_byte(string_bytes[i]);
		end
	endtask

	initial begin
		logic [7:0] directed[$];
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed strings: empty, C0/DEL/C1 controls, bad leads, zero code point,
		// largest code point, missing continuation mid-string and at the terminator
		directed = '{8'h00, 8'h1f, 8'h78, 8'h00, 8'h20, 8'h7f, 8'h00,
			8'hc2, 8'h9f, 8'h00, 8'h80, 8'h00, 8'hff, 8'h00,
			8'he0, 8'h80, 8'h80, 8'h00, 8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'h00,
			8'he2, 8'h82, 8'h41, 8'h00, 8'he2, 8'h00};
		foreach (directed[i]) begin
			send_byte(directed[i]);
		end
		settle_outputs();

		// Random strings under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			while (random_sent < (ph + 1) * RANDOM_BYTES / 4) begin
				send_random_string();
			end
			settle_outputs();
		end

		// Back-pressure: receiver holds off while empty strings keep coming
		idle_pct     = 0;
		stall_pct    = 0;
		hold_request = 1'b1;
		repeat (40) send_byte(8'h00);
		settle_outputs();

		if (fail_count == 0 && outstanding == 0) begin
			$display("utf8_control_char_validator_core test passed");
		end else begin
			$display("utf8_control_char_validator_core test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
